/* design/hmbs_pkg.sv */
package hmbs_pkg;

  localparam int SampleBits  = 16;
  localparam int MaxWidth    = 1024;
  localparam int MaxHeight   = 1024;

  localparam int XBits       = $clog2(MaxWidth);
  localparam int YBits       = $clog2(MaxHeight);
  localparam int WBits       = $clog2(MaxWidth + 1);
  localparam int HBits       = $clog2(MaxHeight + 1);

  localparam int CfgIdxBits  = 1;
  localparam int CfgDataBits = 11;

  localparam int QDepth      = 8;
  localparam int QPtrBits    = $clog2(QDepth);
  localparam int QCntBits    = $clog2(QDepth + 1);

  localparam int ColBits     = SampleBits + 2;
  localparam int SumBits     = SampleBits + 4;
  localparam int MagBits     = SampleBits + 3;
  localparam int RecipShift  = MagBits + 4;
  localparam int RecipBits   = RecipShift - 3;
  localparam int ProdBits    = MagBits + RecipBits;
  localparam longint unsigned Recip = ((64'd1 << RecipShift) + 64'd8) / 64'd9;

  typedef enum logic [CfgIdxBits-1:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_idx_e;

  typedef enum logic {
    PH_FIRST  = 1'b0,
    PH_SECOND = 1'b1
  } back_phase_e;

  typedef struct packed {
    logic [XBits-1:0]             x;
    logic [YBits-1:0]             y;
    logic signed [SampleBits-1:0] height;
    logic                         border;
    logic                         interior;
    logic                         done;
  } item_t;

  typedef struct packed {
    item_t                        info;
    logic signed [SampleBits-1:0] mean;
  } qent_t;

endpackage

/* design/hmbs_ram.sv */
module hmbs_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/hmbs_front.sv */
module hmbs_front
  import hmbs_pkg::*;
(
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [CfgIdxBits-1:0]        cfg_idx_i,
  input  logic [CfgDataBits-1:0]       cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [SampleBits-1:0] sample_height_i,
  input  logic [QCntBits-1:0]          q_count_i,
  output logic                         push_o,
  output qent_t                        push_data_o
);

  localparam int OccBits = QCntBits + 1;

  logic [WBits-1:0] width_q, width_d;
  logic [HBits-1:0] height_q, height_d;
  logic [XBits-1:0] x_q, x_d;
  logic [YBits-1:0] y_q, y_d;

  logic accept;
  logic x_last, y_last;
  item_t cur_item;

  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  item_t s1_q, s2_q, s3_q, s4_q, s5_q;
  logic fwd_q, fwd_d;
  logic [2*SampleBits-1:0] fwd_data_q;

  logic [2*SampleBits-1:0] rdata;
  logic [2*SampleBits-1:0] wdata;
  logic signed [SampleBits-1:0] up_s, mid_s;
  logic signed [ColBits-1:0] col0_q, col1_q, col2_q, col_new;
  logic signed [SumBits-1:0] sum_d, sum_q, abs_v;
  logic [MagBits-1:0] mag_d, mag_q;
  logic neg4_q, neg5_q;
  logic [ProdBits-1:0] prod_d, prod_q;
  logic [SampleBits-1:0] quot;
  logic [OccBits-1:0] occ;

  function automatic logic [WBits-1:0] clamp_w(input logic [CfgDataBits-1:0] v);
    logic [WBits-1:0] r;
    if (v == '0) begin
      r = WBits'(1);
    end else if (v > CfgDataBits'(MaxWidth)) begin
      r = WBits'(MaxWidth);
    end else begin
      r = WBits'(v);
    end
    return r;
  endfunction

  function automatic logic [HBits-1:0] clamp_h(input logic [CfgDataBits-1:0] v);
    logic [HBits-1:0] r;
    if (v == '0) begin
      r = HBits'(1);
    end else if (v > CfgDataBits'(MaxHeight)) begin
      r = HBits'(MaxHeight);
    end else begin
      r = HBits'(v);
    end
    return r;
  endfunction

  assign occ = OccBits'(q_count_i) + OccBits'(v1_q) + OccBits'(v2_q) + OccBits'(v3_q)
             + OccBits'(v4_q) + OccBits'(v5_q);
  assign in_ready_o = occ < OccBits'(QDepth);
  assign accept = in_valid_i && in_ready_o;

  assign x_last = (WBits'(x_q) + WBits'(1)) == width_q;
  assign y_last = (HBits'(y_q) + HBits'(1)) == height_q;

  always_comb begin
    cur_item.x        = x_q;
    cur_item.y        = y_q;
    cur_item.height   = sample_height_i;
    cur_item.border   = (x_q == '0) || (y_q == '0) || x_last || y_last;
    cur_item.interior = (x_q >= XBits'(2)) && (y_q >= YBits'(2));
    cur_item.done     = x_last && y_last;
  end

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    x_d      = x_q;
    y_d      = y_q;
    if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_FRAME_WIDTH:  width_d = clamp_w(cfg_wdata_i);
        REG_FRAME_HEIGHT: height_d = clamp_h(cfg_wdata_i);
        default: ;
      endcase
      x_d = '0;
      y_d = '0;
    end else if (accept) begin
      if (x_last) begin
        x_d = '0;
        y_d = y_last ? '0 : y_q + YBits'(1);
      end else begin
        x_d = x_q + XBits'(1);
      end
    end
  end

  hmbs_ram #(
    .Width (2 * SampleBits),
    .Depth (MaxWidth)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (v1_q),
    .waddr_i (s1_q.x),
    .wdata_i (wdata),
    .re_i    (accept),
    .raddr_i (x_q),
    .rdata_o (rdata)
  );

  assign up_s    = fwd_q ? fwd_data_q[2*SampleBits-1:SampleBits] : rdata[2*SampleBits-1:SampleBits];
  assign mid_s   = fwd_q ? fwd_data_q[SampleBits-1:0] : rdata[SampleBits-1:0];
  assign wdata   = {mid_s, s1_q.height};
  assign col_new = ColBits'(up_s) + ColBits'(mid_s) + ColBits'(s1_q.height);
  assign fwd_d   = accept && v1_q && (s1_q.x == x_q);

  assign sum_d  = SumBits'(col0_q) + SumBits'(col1_q) + SumBits'(col2_q);
  assign abs_v  = sum_q[SumBits-1] ? -sum_q : sum_q;
  assign mag_d  = MagBits'(abs_v) + MagBits'(4);
  assign prod_d = ProdBits'(mag_q) * ProdBits'(RecipBits'(Recip));
  assign quot   = prod_q[RecipShift +: SampleBits];

  assign push_o                 = v5_q && (s5_q.border || s5_q.interior);
  assign push_data_o.info       = s5_q;
  assign push_data_o.mean       = neg5_q ? -quot : quot;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WBits'(64);
      height_q <= HBits'(64);
      x_q      <= '0;
      y_q      <= '0;
      v1_q     <= 1'b0;
      v2_q     <= 1'b0;
      v3_q     <= 1'b0;
      v4_q     <= 1'b0;
      v5_q     <= 1'b0;
      fwd_q    <= 1'b0;
      col0_q   <= '0;
      col1_q   <= '0;
      col2_q   <= '0;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
      x_q      <= x_d;
      y_q      <= y_d;
      v1_q     <= accept;
      v2_q     <= v1_q;
      v3_q     <= v2_q;
      v4_q     <= v3_q;
      v5_q     <= v4_q;
      fwd_q    <= fwd_d;
      if (v1_q) begin
        col0_q <= col1_q;
        col1_q <= col2_q;
        col2_q <= col_new;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= cur_item;
    end
    if (fwd_d) begin
      fwd_data_q <= wdata;
    end
    s2_q    <= s1_q;
    s3_q    <= s2_q;
    sum_q   <= sum_d;
    s4_q    <= s3_q;
    mag_q   <= mag_d;
    neg4_q  <= sum_q[SumBits-1];
    s5_q    <= s4_q;
    prod_q  <= prod_d;
    neg5_q  <= neg4_q;
  end

`ifndef SYNTH
  a_pos_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (WBits'(x_q) < width_q) && (HBits'(y_q) < height_q))
    else $error("position outside frame");

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ <= OccBits'(QDepth))
    else $error("more items in flight than queue slots");

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> v1_q && (s1_q.x == $past(x_q)))
    else $error("accepted item missing from first stage");
`endif

endmodule

/* design/hmbs_queue.sv */
module hmbs_queue
  import hmbs_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  qent_t               push_data_i,
  input  logic                pop_i,
  output qent_t               head_o,
  output logic                empty_o,
  output logic [QCntBits-1:0] count_o
);

  qent_t mem_q [QDepth];
  logic [QPtrBits-1:0] wr_q, rd_q;
  logic [QCntBits-1:0] cnt_q, cnt_d;

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + QCntBits'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - QCntBits'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_q <= wr_q + QPtrBits'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + QPtrBits'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  assign head_o  = mem_q[rd_q];
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (cnt_q < QCntBits'(QDepth)) || pop_i)
    else $error("queue overflow");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("queue underflow");
`endif

endmodule

/* design/hmbs_back.sv */
module hmbs_back
  import hmbs_pkg::*;
(
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         q_empty_i,
  input  qent_t                        head_i,
  output logic                         pop_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [XBits-1:0]             out_x_o,
  output logic [YBits-1:0]             out_y_o,
  output logic signed [SampleBits-1:0] out_height_o,
  output logic                         last_of_run_o,
  output logic                         frame_done_o
);

  back_phase_e phase_q, phase_d;
  logic load;
  logic emit_inner;
  logic pair;

  logic out_valid_q, out_valid_d;
  logic [XBits-1:0] x_q, x_d;
  logic [YBits-1:0] y_q, y_d;
  logic signed [SampleBits-1:0] h_q, h_d;
  logic last_q, last_d;
  logic done_q, done_d;

  assign load       = !q_empty_i && (!out_valid_q || out_ready_i);
  assign pair       = head_i.info.interior && head_i.info.border;
  assign emit_inner = head_i.info.interior && (phase_q == PH_FIRST);

  always_comb begin
    phase_d = phase_q;
    if (load) begin
      unique case (phase_q)
        PH_FIRST:  if (pair) phase_d = PH_SECOND;
        PH_SECOND: phase_d = PH_FIRST;
        default:   phase_d = PH_FIRST;
      endcase
    end
  end

  always_comb begin
    pop_o       = load && ((phase_q == PH_SECOND) || !pair);
    out_valid_d = load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
    if (emit_inner) begin
      x_d    = head_i.info.x - XBits'(1);
      y_d    = head_i.info.y - YBits'(1);
      h_d    = head_i.mean;
      last_d = !head_i.info.border;
      done_d = 1'b0;
    end else begin
      x_d    = head_i.info.x;
      y_d    = head_i.info.y;
      h_d    = head_i.info.height;
      last_d = 1'b1;
      done_d = head_i.info.done;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_FIRST;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      x_q    <= x_d;
      y_q    <= y_d;
      h_q    <= h_d;
      last_q <= last_d;
      done_q <= done_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_x_o       = x_q;
  assign out_y_o       = y_q;
  assign out_height_o  = h_q;
  assign last_of_run_o = last_q;
  assign frame_done_o  = done_q;

`ifndef SYNTH
  a_second_half: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_SECOND) |-> !q_empty_i && pair)
    else $error("second result without a paired item at the head");
`endif

endmodule

/* design/heightmap_box_smooth_3x3_top.sv */
// channel  | handshake                 | payload
// cfg      | cfg_we_i                  | cfg_idx_i, cfg_wdata_i
// in       | in_valid_i / in_ready_o   | sample_height_i
// out      | out_valid_o / out_ready_i | out_x_o, out_y_o, out_height_o, last_of_run_o,
//          |                           | frame_done_o
//
// One sample accepted per cycle while in_ready_o is high; a sample yielding two results holds the emitter for both.
// The first result of a sample passes through the 5-stage window/mean pipeline, the queue and
// the output register.
// in_ready_o drops while the queue plus the pipeline hold 8 items.
// Reset sets 64 x 64 and position (0,0); line stores are not cleared and need no pass.
module heightmap_box_smooth_3x3_top
  import hmbs_pkg::*;
(
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [CfgIdxBits-1:0]        cfg_idx_i,
  input  logic [CfgDataBits-1:0]       cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [SampleBits-1:0] sample_height_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [XBits-1:0]             out_x_o,
  output logic [YBits-1:0]             out_y_o,
  output logic signed [SampleBits-1:0] out_height_o,
  output logic                         last_of_run_o,
  output logic                         frame_done_o
);

  logic push;
  qent_t push_data;
  logic pop;
  qent_t head;
  logic q_empty;
  logic [QCntBits-1:0] q_count;

  hmbs_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .sample_height_i (sample_height_i),
    .q_count_i       (q_count),
    .push_o          (push),
    .push_data_o     (push_data)
  );

  hmbs_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .head_o      (head),
    .empty_o     (q_empty),
    .count_o     (q_count)
  );

  hmbs_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_empty_i     (q_empty),
    .head_i        (head),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_x_o       (out_x_o),
    .out_y_o       (out_y_o),
    .out_height_o  (out_height_o),
    .last_of_run_o (last_of_run_o),
    .frame_done_o  (frame_done_o)
  );

endmodule

/* verif/heightmap_box_smooth_3x3_top_test.sv */
module heightmap_box_smooth_3x3_top_test;
  import hmbs_pkg::*;

  localparam int DrainCycles   = 20;
  localparam int WatchdogLimit = 4000;
  localparam int ItemsPerMode  = 100;

  typedef struct packed {
    logic [XBits-1:0]             x;
    logic [YBits-1:0]             y;
    logic signed [SampleBits-1:0] height;
    logic                         last;
    logic                         done;
  } height_result_t;

  class smooth_scoreboard;
    logic signed [SampleBits-1:0] row_above [MaxWidth];
    logic signed [SampleBits-1:0] row_prev [MaxWidth];
    logic signed [SampleBits-1:0] win [3][3];
    int unsigned col, row, width, height;
    height_result_t expected_q[$];
    int n_errors, n_samples, n_results, n_writes;

    function new();
      foreach (row_above[i]) begin
        row_above[i] = '0;
        row_prev[i]  = '0;
      end
      foreach (win[c, k]) win[c][k] = '0;
      col = 0;
      row = 0;
      width = 64;
      height = 64;
      n_errors = 0;
      n_samples = 0;
      n_results = 0;
      n_writes = 0;
    endfunction

    function int unsigned clamp_size(logic [CfgDataBits-1:0] v, int unsigned lim);
      if (v == 0) return 1;
      if (int'(v) > lim) return lim;
      return int'(v);
    endfunction

    function void set_reg(reg_idx_e idx, logic [CfgDataBits-1:0] v);
      case (idx)
        REG_FRAME_WIDTH:  width  = clamp_size(v, MaxWidth);
        REG_FRAME_HEIGHT: height = clamp_size(v, MaxHeight);
        default: return;
      endcase
      col = 0;
      row = 0;
      n_writes++;
    endfunction

    function logic signed [SampleBits-1:0] window_mean();
      longint s;
      longint m;
      s = 0;
      for (int c = 0; c < 3; c++)
        for (int k = 0; k < 3; k++) s += longint'(win[c][k]);
      if (s >= 0) m = (s + 4) / 9;
      else m = -((-s + 4) / 9);
      return m[SampleBits-1:0];
    endfunction

    function void note_sample(logic signed [SampleBits-1:0] h);
      int unsigned x, y;
      bit border, interior, done;
      height_result_t r;
      x = col;
      y = row;
      if (x >= width || x >= MaxWidth) x = 0;
      if (y >= height) y = 0;
      for (int c = 0; c < 2; c++)
        for (int k = 0; k < 3; k++) win[c][k] = win[c+1][k];
      win[2][0] = row_above[x];
      win[2][1] = row_prev[x];
      win[2][2] = h;
      row_above[x] = row_prev[x];
      row_prev[x]  = h;
      border   = (x == 0) || (y == 0) || (x + 1 == width) || (y + 1 == height);
      interior = (x >= 2) && (y >= 2);
      if (interior) begin
        r.x = XBits'(x - 1);
        r.y = YBits'(y - 1);
        r.height = window_mean();
        r.last = !border;
        r.done = 1'b0;
        expected_q.push_back(r);
      end
      if (border) begin
        done = (x + 1 == width) && (y + 1 == height);
        r.x = XBits'(x);
        r.y = YBits'(y);
        r.height = h;
        r.last = 1'b1;
        r.done = done;
        expected_q.push_back(r);
      end
      n_samples++;
      x++;
      if (x >= width) begin
        x = 0;
        y++;
        if (y >= height) y = 0;
      end
      col = x;
      row = y;
    endfunction

    function void check_result(height_result_t got);
      height_result_t want;
      bit ok;
      n_results++;
      if (expected_q.size() == 0) begin
        if (n_errors < 10)
          $display("ERROR: unexpected result x=%0d y=%0d h=%0d last=%0b done=%0b",
                   got.x, got.y, got.height, got.last, got.done);
        n_errors++;
        return;
      end
      want = expected_q.pop_front();
      ok = (got.x === want.x) && (got.y === want.y) && (got.height === want.height) &&
           (got.last === want.last) && (got.done === want.done);
      if (!ok) begin
        if (n_errors < 10) begin
          $display("ERROR: result %0d exp x=%0d y=%0d h=%0d last=%0b done=%0b,",
                   n_results, want.x, want.y, want.height, want.last, want.done);
          $display("       got x=%0d y=%0d h=%0d last=%0b done=%0b",
                   got.x, got.y, got.height, got.last, got.done);
        end
        n_errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void check_leftover();
      if (expected_q.size() != 0) begin
        $display("ERROR: %0d expected results never arrived", expected_q.size());
        n_errors += expected_q.size();
      end
    endfunction
  endclass

  logic                         clk_i;
  logic                         rst_ni;
  logic                         cfg_we_i;
  logic [CfgIdxBits-1:0]        cfg_idx_i;
  logic [CfgDataBits-1:0]       cfg_wdata_i;
  logic                         in_valid_i;
  logic                         in_ready_o;
  logic signed [SampleBits-1:0] sample_height_i;
  logic                         out_valid_o;
  logic                         out_ready_i;
  logic [XBits-1:0]             out_x_o;
  logic [YBits-1:0]             out_y_o;
  logic signed [SampleBits-1:0] out_height_o;
  logic                         last_of_run_o;
  logic                         frame_done_o;

  smooth_scoreboard sb;
  int send_idle_pct;
  int recv_stall_pct;
  int random_items;
  int idle_cycles;

  heightmap_box_smooth_3x3_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .sample_height_i(sample_height_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_x_o        (out_x_o),
    .out_y_o        (out_y_o),
    .out_height_o   (out_height_o),
    .last_of_run_o  (last_of_run_o),
    .frame_done_o   (frame_done_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    height_result_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.x = out_x_o;
      got.y = out_y_o;
      got.height = out_height_o;
      got.last = last_of_run_o;
      got.done = frame_done_o;
      sb.check_result(got);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WatchdogLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send_sample(input logic signed [SampleBits-1:0] h);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    sample_height_i = h;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_sample(h);
  endtask

  // hold the input low until every result is out, then let the pipeline settle
  task automatic drain();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [CfgDataBits-1:0] v);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_wdata_i = v;
    @(posedge clk_i);
    sb.set_reg(idx, v);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic set_frame(input logic [CfgDataBits-1:0] w, input logic [CfgDataBits-1:0] h);
    drain();
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, h);
  endtask

  function automatic logic signed [SampleBits-1:0] pick_height();
    case ($urandom_range(0, 9))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2, 3: return SampleBits'(int'($urandom_range(0, 40)) - 20);
      default: return SampleBits'($urandom);
    endcase
  endfunction

  function automatic logic [CfgDataBits-1:0] pick_size();
    case ($urandom_range(0, 19))
      0: return '0;
      1: return CfgDataBits'($urandom_range(MaxWidth + 1, 2047));
      2: return CfgDataBits'(MaxWidth);
      3, 4: return CfgDataBits'($urandom_range(13, 40));
      default: return CfgDataBits'($urandom_range(1, 12));
    endcase
  endfunction

  task automatic run_segment();
    int unsigned area, total;
    set_frame(pick_size(), pick_size());
    area = sb.width * sb.height;
    if (area <= 240) begin
      total = area * $urandom_range(1, 3);
      if ($urandom_range(0, 4) == 0) total = $urandom_range(1, total);
    end else begin
      total = $urandom_range(1, 80);
    end
    for (int unsigned i = 0; i < total; i++) begin
      send_sample(pick_height());
      random_items++;
      if ($urandom_range(0, 49) == 0) drain();
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_FRAME_WIDTH;
    cfg_wdata_i = '0;
    in_valid_i = 1'b0;
    sample_height_i = '0;
    out_ready_i = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    random_items = 0;
    idle_cycles = 0;
    sb = new();
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset size, cut short by the following writes
    send_sample(16'sh7fff);
    send_sample(16'sh8000);
    send_sample(16'sh0000);
    send_sample(-16'sh0001);
    set_frame(CfgDataBits'(3), CfgDataBits'(3));
    repeat (9) send_sample(16'sh7fff);
    repeat (9) send_sample(16'sh8000);
    set_frame('0, '0);
    send_sample(16'sh1234);
    send_sample(-16'sh1234);

    set_frame(CfgDataBits'(2047), CfgDataBits'(2));
    repeat (MaxWidth + 2) send_sample(pick_height());
    set_frame(CfgDataBits'(1), CfgDataBits'(2047));
    repeat (40) send_sample(pick_height());

    for (int mode = 0; mode < 4; mode++) begin
      case (mode)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
        default: begin send_idle_pct = 23; recv_stall_pct = 23; end
      endcase
      while (random_items < ItemsPerMode * (mode + 1)) run_segment();
    end

    drain();
    sb.check_leftover();
    $display("Run covered %0d samples and %0d results across %0d size writes,",
             sb.n_samples, sb.n_results, sb.n_writes);
    $display("frames from 1x1 to 1024 wide or tall, under four handshake pressure mixes.");
    if (sb.n_errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", sb.n_errors);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
